/* hw/rtl/mwf_pkg.sv */
// mwf_pkg: shared types and constants of the median window filter.
// No dependencies; imported by every module of the block but mwf_ram.
package mwf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_WINDOW = 7;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 12;
  localparam int RM_W       = 3;
  localparam int LS_AW      = RM_W + COL_W;
  localparam int LS_DEPTH   = MAX_WINDOW * MAX_WIDTH;
  localparam int WIN_DEPTH  = MAX_WINDOW * MAX_WINDOW;
  localparam int WIN_AW     = 6;
  localparam int SEEN_W     = 23;

  localparam logic [1:0] CFG_FRAME_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT  = 2'd1;
  localparam logic [1:0] CFG_WINDOW_RADIUS = 2'd2;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       last_of_frame;
  } out_item_t;

  // effective frame geometry
  typedef struct packed {
    logic [10:0] w;
    logic [12:0] h;
    logic [1:0]  r;
  } geo_t;

  // one result to compute: centre position and last flag
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [RM_W-1:0]  rowmod;
    logic             last;
  } job_t;

endpackage

/* hw/rtl/mwf_ram.sv */
// mwf_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
module mwf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/mwf_front.sv */
// mwf_front: config registers, request intake and classification, line store writes.
// Depends on mwf_pkg; issues jobs to mwf_back.
module mwf_front import mwf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [12:0]      cfg_data,
  input  logic             in_push,
  input  in_item_t         in_data,
  output logic             in_full,
  input  logic             gather_busy,
  input  logic             job_take,
  output logic             job_valid,
  output job_t             job,
  output geo_t             geo,
  output logic             ls_we,
  output logic [LS_AW-1:0] ls_waddr,
  output logic [23:0]      ls_wdata
);

  logic [10:0] width_r;
  logic [12:0] height_r;
  logic [1:0]  radius_r;
  logic [SEEN_W-1:0] total_r, end_r, total_nxt, end_nxt;
  logic [11:0] lag_r, lag_nxt;
  logic [SEEN_W-1:0] seen_r, seen_nxt;
  logic [COL_W-1:0]  icol_r, icol_nxt, ocol_r, ocol_nxt;
  logic [RM_W-1:0]   irm_r, irm_nxt, orm_r, orm_nxt;
  logic [ROW_W-1:0]  orow_r, orow_nxt;
  logic              jv_r, jv_nxt;
  logic              cfg_pend_r;
  job_t              job_r, job_nxt;

  logic              accept, wrap, is_flush, ignore, upd, pix, gen;
  logic [SEEN_W-1:0] n;
  logic [COL_W-1:0]  ic, oc;
  logic [RM_W-1:0]   irm, orm;
  logic [ROW_W-1:0]  orow;

  always_comb begin
    geo.w = (width_r == 11'd0) ? 11'd1 :
            (width_r > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : width_r;
    geo.h = (height_r == 13'd0) ? 13'd1 : height_r;
    geo.r = radius_r;
    total_nxt = SEEN_W'(geo.w * geo.h);
    lag_nxt   = 12'(geo.r * geo.w) + 12'(geo.r);
    end_nxt   = total_nxt + SEEN_W'(lag_nxt);
  end

  // hold intake in the cycle after a register write so the frame totals settle
  assign in_full   = jv_r | gather_busy | cfg_pend_r;
  assign job_valid = jv_r;
  assign job       = job_r;

  always_comb begin
    accept   = in_push & ~in_full;
    wrap     = seen_r >= end_r;
    is_flush = in_data.action == ACT_FLUSH;
    ignore   = is_flush & (wrap | (seen_r < total_r));
    upd      = accept & ~ignore;
    n        = wrap ? '0 : seen_r;
    ic       = wrap ? '0 : icol_r;
    irm      = wrap ? '0 : irm_r;
    oc       = wrap ? '0 : ocol_r;
    orm      = wrap ? '0 : orm_r;
    orow     = wrap ? '0 : orow_r;
    pix      = upd & (n < total_r);
    gen      = upd & (n >= SEEN_W'(lag_r)) & (n < end_r);

    seen_nxt = seen_r;
    icol_nxt = icol_r;
    irm_nxt  = irm_r;
    ocol_nxt = ocol_r;
    orm_nxt  = orm_r;
    orow_nxt = orow_r;
    jv_nxt   = jv_r & ~job_take;
    job_nxt  = job_r;

    ls_we    = pix;
    ls_waddr = {irm, ic};
    ls_wdata = {in_data.in_red, in_data.in_green, in_data.in_blue};

    if (upd) begin
      seen_nxt = n + 1'b1;
      ocol_nxt = oc;
      orm_nxt  = orm;
      orow_nxt = orow;
      icol_nxt = ic;
      irm_nxt  = irm;
    end
    if (pix) begin
      if ({1'b0, ic} + 11'd1 >= geo.w) begin
        icol_nxt = '0;
        irm_nxt  = (irm == RM_W'(MAX_WINDOW - 1)) ? '0 : irm + 1'b1;
      end else begin
        icol_nxt = ic + 1'b1;
      end
    end
    if (gen) begin
      jv_nxt       = 1'b1;
      job_nxt.row  = orow;
      job_nxt.col  = oc;
      job_nxt.rowmod = orm;
      job_nxt.last = (n + 1'b1) == end_r;
      if ({1'b0, oc} + 11'd1 >= geo.w) begin
        ocol_nxt = '0;
        orow_nxt = orow + 1'b1;
        orm_nxt  = (orm == RM_W'(MAX_WINDOW - 1)) ? '0 : orm + 1'b1;
      end else begin
        ocol_nxt = oc + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd64;
      height_r <= 13'd64;
      radius_r <= 2'd1;
      total_r  <= SEEN_W'(4096);
      lag_r    <= 12'd65;
      end_r    <= SEEN_W'(4161);
      seen_r   <= '0;
      icol_r   <= '0;
      irm_r    <= '0;
      ocol_r   <= '0;
      orm_r    <= '0;
      orow_r   <= '0;
      jv_r     <= 1'b0;
      cfg_pend_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_FRAME_WIDTH)   width_r  <= cfg_data[10:0];
      if (cfg_we && cfg_index == CFG_FRAME_HEIGHT)  height_r <= cfg_data;
      if (cfg_we && cfg_index == CFG_WINDOW_RADIUS) radius_r <= cfg_data[1:0];
      total_r <= total_nxt;
      lag_r   <= lag_nxt;
      end_r   <= end_nxt;
      seen_r  <= seen_nxt;
      icol_r  <= icol_nxt;
      irm_r   <= irm_nxt;
      ocol_r  <= ocol_nxt;
      orm_r   <= orm_nxt;
      orow_r  <= orow_nxt;
      jv_r    <= jv_nxt;
      cfg_pend_r <= cfg_we;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

endmodule

/* hw/rtl/mwf_back.sv */
// mwf_back: window gather from the line store, bitwise rank selection, result register.
// Depends on mwf_pkg and mwf_ram.
module mwf_back import mwf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  geo_t             geo,
  input  logic             job_valid,
  input  job_t             job,
  output logic             job_take,
  output logic             gather_busy,
  output logic [LS_AW-1:0] ls_raddr,
  input  logic [23:0]      ls_rdata,
  output logic             out_empty,
  input  logic             out_pop,
  output out_item_t        out_data
);

  localparam logic [2:0] B_IDLE   = 3'd0;
  localparam logic [2:0] B_GATHER = 3'd1;
  localparam logic [2:0] B_GDRAIN = 3'd2;
  localparam logic [2:0] B_SEL    = 3'd3;
  localparam logic [2:0] B_OUT    = 3'd4;

  logic [2:0]        st_r, st_nxt;
  job_t              job_r, job_nxt;
  logic [2:0]        a_r, a_nxt, b_r, b_nxt, bit_r, bit_nxt;
  logic [WIN_AW-1:0] cnt_r, cnt_nxt, i_r, i_nxt;
  logic              rdv_r, rdv_nxt, sv_r, sv_nxt, ov_r, ov_nxt;
  logic [5:0]        k_r [3];
  logic [5:0]        k_nxt [3];
  logic [5:0]        c0_r [3];
  logic [5:0]        c0_nxt [3];
  logic [7:0]        pre_r [3];
  logic [7:0]        pre_nxt [3];
  out_item_t         od_r, od_nxt;

  logic [2:0]        span;
  logic signed [13:0] yy;
  logic signed [11:0] xx;
  logic signed [4:0]  rm;
  logic              inframe;
  logic [23:0]       win_rdata;
  logic [7:0]        mask, v;

  mwf_ram #(.WIDTH(24), .DEPTH(WIN_DEPTH)) u_win (
    .clk   (clk),
    .we    (rdv_r),
    .waddr (cnt_r),
    .wdata (ls_rdata),
    .raddr (i_r),
    .rdata (win_rdata)
  );

  assign gather_busy = (st_r == B_GATHER) || (st_r == B_GDRAIN);
  assign job_take    = (st_r == B_IDLE) && job_valid;
  assign out_empty   = ~ov_r;
  assign out_data    = od_r;

  always_comb begin
    span = {geo.r, 1'b0};
    yy   = $signed({2'b00, job_r.row}) + $signed({11'd0, a_r}) - $signed({12'd0, geo.r});
    xx   = $signed({2'b00, job_r.col}) + $signed({9'd0, b_r}) - $signed({10'd0, geo.r});
    rm   = $signed({2'b00, job_r.rowmod}) + $signed({2'b00, a_r}) - $signed({3'd0, geo.r});
    if (rm < 0) rm = rm + 5'sd7;
    else if (rm >= 5'sd7) rm = rm - 5'sd7;
    inframe = (yy >= 0) && (yy < $signed({1'b0, geo.h})) &&
              (xx >= 0) && (xx < $signed({1'b0, geo.w}));
    ls_raddr = {rm[RM_W-1:0], xx[COL_W-1:0]};
    mask = 8'hFF << ({1'b0, bit_r} + 4'd1);

    st_nxt  = st_r;
    job_nxt = job_r;
    a_nxt   = a_r;
    b_nxt   = b_r;
    bit_nxt = bit_r;
    cnt_nxt = cnt_r + WIN_AW'(rdv_r);
    i_nxt   = i_r;
    rdv_nxt = 1'b0;
    sv_nxt  = 1'b0;
    ov_nxt  = ov_r & ~out_pop;
    od_nxt  = od_r;
    v       = '0;
    for (int c = 0; c < 3; c++) begin
      k_nxt[c]   = k_r[c];
      c0_nxt[c]  = c0_r[c];
      pre_nxt[c] = pre_r[c];
    end

    case (st_r)
      B_IDLE: begin
        if (job_valid) begin
          job_nxt = job;
          a_nxt   = '0;
          b_nxt   = '0;
          cnt_nxt = '0;
          st_nxt  = B_GATHER;
        end
      end
      B_GATHER: begin
        rdv_nxt = inframe;
        if (b_r == span) begin
          b_nxt = '0;
          if (a_r == span) st_nxt = B_GDRAIN;
          else a_nxt = a_r + 1'b1;
        end else begin
          b_nxt = b_r + 1'b1;
        end
      end
      B_GDRAIN: begin
        // last line store read lands this cycle
        i_nxt   = '0;
        bit_nxt = 3'd7;
        for (int c = 0; c < 3; c++) begin
          k_nxt[c]   = 6'(cnt_nxt >> 1);
          c0_nxt[c]  = '0;
          pre_nxt[c] = '0;
        end
        st_nxt = B_SEL;
      end
      B_SEL: begin
        if (i_r < cnt_r) begin
          i_nxt  = i_r + 1'b1;
          sv_nxt = 1'b1;
        end
        if (sv_r) begin
          for (int c = 0; c < 3; c++) begin
            v = win_rdata[23 - 8*c -: 8];
            if ((((v ^ pre_r[c]) & mask) == 8'd0) && !v[bit_r]) c0_nxt[c] = c0_r[c] + 1'b1;
          end
        end
        if (i_r >= cnt_r && !sv_r) begin
          // end of one bit pass: pick the half holding the wanted rank
          for (int c = 0; c < 3; c++) begin
            if (k_r[c] >= c0_r[c]) begin
              pre_nxt[c][bit_r] = 1'b1;
              k_nxt[c] = k_r[c] - c0_r[c];
            end
            c0_nxt[c] = '0;
          end
          i_nxt = '0;
          if (bit_r == 3'd0) st_nxt = B_OUT;
          else bit_nxt = bit_r - 1'b1;
        end
      end
      B_OUT: begin
        if (!ov_r || out_pop) begin
          ov_nxt = 1'b1;
          od_nxt.out_red       = (cnt_r == '0) ? 8'd0 : pre_r[0];
          od_nxt.out_green     = (cnt_r == '0) ? 8'd0 : pre_r[1];
          od_nxt.out_blue      = (cnt_r == '0) ? 8'd0 : pre_r[2];
          od_nxt.last_of_frame = job_r.last;
          st_nxt = B_IDLE;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= B_IDLE;
      rdv_r <= 1'b0;
      sv_r  <= 1'b0;
      ov_r  <= 1'b0;
      cnt_r <= '0;
      i_r   <= '0;
    end else begin
      st_r  <= st_nxt;
      rdv_r <= rdv_nxt;
      sv_r  <= sv_nxt;
      ov_r  <= ov_nxt;
      cnt_r <= cnt_nxt;
      i_r   <= i_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    bit_r <= bit_nxt;
    od_r  <= od_nxt;
    for (int c = 0; c < 3; c++) begin
      k_r[c]   <= k_nxt[c];
      c0_r[c]  <= c0_nxt[c];
      pre_r[c] <= pre_nxt[c];
    end
  end

endmodule

/* hw/rtl/median_window_filter_unit.sv */
// Flow: a request with no result is absorbed by the front end alone. A result waits
// for the gather of its window from the line store port and the 8 rank passes over
// the n in-frame pixels held in the window RAM.
// Intake stalls during a gather, while a job waits for the back end and in the cycle after a write.
// Reset (synchronous, rst_n low): counters cleared, registers back to 64x64, radius 1.
// Depends on mwf_pkg, mwf_ram, mwf_front and mwf_back.
module median_window_filter_unit import mwf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic      in_push,
  input  in_item_t  in_data,
  output logic      in_full,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_data
);

  logic             gather_busy, job_take, job_valid, ls_we;
  job_t             job;
  geo_t             geo;
  logic [LS_AW-1:0] ls_waddr, ls_raddr;
  logic [23:0]      ls_wdata, ls_rdata;

  mwf_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_push, .in_data, .in_full,
    .gather_busy, .job_take, .job_valid, .job, .geo,
    .ls_we, .ls_waddr, .ls_wdata
  );

  mwf_ram #(.WIDTH(24), .DEPTH(LS_DEPTH)) u_lines (
    .clk   (clk),
    .we    (ls_we),
    .waddr (ls_waddr),
    .wdata (ls_wdata),
    .raddr (ls_raddr),
    .rdata (ls_rdata)
  );

  mwf_back u_back (
    .clk, .rst_n, .geo, .job_valid, .job, .job_take, .gather_busy,
    .ls_raddr, .ls_rdata, .out_empty, .out_pop, .out_data
  );

endmodule

/* hw/rtl/mwf_checker.sv */
// mwf_checker: port-level checks of median_window_filter_unit, bound to it.
// Depends on mwf_pkg.
module mwf_checker import mwf_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_push,
  input logic      in_full,
  input logic      out_empty,
  input logic      out_pop,
  input out_item_t out_data
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_reset_ready: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("intake full after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("waiting result changed or vanished");

endmodule

bind median_window_filter_unit mwf_checker u_mwf_checker (.*);
